// File: sv/gsp_pkg.sv
// gsp_pkg: shared types and constants of the guillotine slot packer
// slot layout, fsm state type, stream and configuration field widths
// no dependencies
`default_nettype none

package gsp_pkg;

    localparam int SLOT_W     = 64;
    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] PAGE_SIZE_RST = 16'd1024;
    localparam logic [7:0]  GUTTER_RST    = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUTTER    = 1'b1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    // u in the lowest bits
    typedef struct packed {
        logic [15:0] vres;
        logic [15:0] ures;
        logic [15:0] v;
        logic [15:0] u;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_RIGHT,
        S_BOTTOM,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: sv/gsp_ram.sv
// gsp_ram: generic simple dual port ram, one write and one registered read port
// used for the free slot list; no dependencies
`default_nettype none

module gsp_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 32
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [DATA_W-1:0]        i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/guillotine_slot_packer.sv
// guillotine_slot_packer: first-fit rectangle packer over an ordered free slot list
// depends on gsp_pkg and gsp_ram
//
//   channel   dir  handshake                      payload
//   s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser action, tdata log2 sizes
//   m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tuser status, tdata position, full
//   cfg       in   i_cfg_valid/o_cfg_ready          register index and data
//
// clear writes one page slot; an allocate finds the first fit, moves entries and writes
// the remainders; a miss ends after the search; all use the single slot ram port pair
// one item is worked at a time; the result register frees the input side
// reset is synchronous and empties the list; slot ram contents are not cleared
// a stalled output holds the next finished item in the done state
`default_nettype none

module guillotine_slot_packer #(
    parameter int MAX_SLOTS = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire  [gsp_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,  // width_log2, height_log2
    input  wire  [gsp_pkg::S_TUSER_W-1:0]      i_s_axis_tuser,  // action
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    output logic [gsp_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,  // pos_u, pos_v, page_full
    output logic [gsp_pkg::M_TUSER_W-1:0]      o_m_axis_tuser,  // status
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [gsp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [gsp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import gsp_pkg::*;

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SLOTS);

    t_state r_state, n_state;

    logic [15:0]   r_page;
    logic [7:0]    r_gutter;
    logic [CW-1:0] r_count;
    logic [16:0]   r_need_w, r_need_h;
    logic [CW-1:0] r_rd_idx;
    logic          r_chk_valid;
    logic [IW-1:0] r_chk_idx;
    t_slot         r_used;
    logic          r_has_right, r_has_bottom;
    logic [IW-1:0] r_src;
    logic [CW-1:0] r_left;
    logic          r_pend;
    logic [IW-1:0] r_pend_dst;
    logic [1:0]    r_status;
    logic [15:0]   r_pos_u, r_pos_v;
    logic          r_full;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [M_TDATA_W-1:0] r_out_data;

    logic          in_acc, out_free;
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    t_slot         ram_wdata, rd_slot;
    logic [SLOT_W-1:0] ram_rdata;
    logic          fit, hit, miss, issue;
    logic          nb_right, nb_bottom;
    logic [CW-1:0] cnt_mid, cnt_final;
    logic          dropped;
    logic [16:0]   need_w_in, need_h_in;
    t_slot         right_slot, bottom_slot, page_slot;

    assign rd_slot = ram_rdata;

    gsp_ram #(
        .DATA_W (SLOT_W),
        .DEPTH  (MAX_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign need_w_in = (17'd1 << i_s_axis_tdata[3:0]) + {8'd0, r_gutter, 1'b0};
    assign need_h_in = (17'd1 << i_s_axis_tdata[7:4]) + {8'd0, r_gutter, 1'b0};

    assign fit  = r_chk_valid && ({1'b0, rd_slot.ures} >= r_need_w)
                              && ({1'b0, rd_slot.vres} >= r_need_h);
    assign hit   = (r_state == S_SEARCH) && fit;
    assign miss  = (r_state == S_SEARCH) && !fit && (r_rd_idx == r_count);
    assign issue = r_rd_idx < r_count;

    assign nb_right  = {1'b0, rd_slot.ures} > r_need_w;
    assign nb_bottom = {1'b0, rd_slot.vres} > r_need_h;

    assign cnt_mid   = r_has_right ? r_count : r_count - CW'(1);
    assign dropped   = r_has_bottom && (cnt_mid == MAX_CNT);
    assign cnt_final = (r_has_bottom && !dropped) ? cnt_mid + CW'(1) : cnt_mid;

    always_comb begin
        page_slot      = '0;
        page_slot.ures = r_page;
        page_slot.vres = r_page;

        right_slot      = r_used;
        right_slot.u    = r_used.u + r_need_w[15:0];
        right_slot.ures = r_used.ures - r_need_w[15:0];
        right_slot.vres = r_need_h[15:0];

        bottom_slot      = r_used;
        bottom_slot.v    = r_used.v + r_need_h[15:0];
        bottom_slot.vres = r_used.vres - r_need_h[15:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_s_axis_tuser[0] == ACT_CLEAR) ? S_DONE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_state = S_SHIFT;
                end else if (miss) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (r_left == '0) begin
                    n_state = S_RIGHT;
                end
            end
            S_RIGHT:  n_state = S_BOTTOM;
            S_BOTTOM: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // slot ram controls
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = rd_slot;
        ram_re    = 1'b0;
        ram_raddr = r_src;
        case (r_state)
            S_IDLE: begin
                ram_we    = in_acc && (i_s_axis_tuser[0] == ACT_CLEAR);
                ram_wdata = page_slot;
            end
            S_SEARCH: begin
                ram_re    = issue;
                ram_raddr = r_rd_idx[IW-1:0];
            end
            S_SHIFT: begin
                ram_re    = (r_left != '0);
                ram_we    = r_pend;
                ram_waddr = r_pend_dst;
            end
            S_RIGHT: begin
                ram_we    = r_has_right;
                ram_wdata = right_slot;
            end
            S_BOTTOM: begin
                ram_we    = r_has_bottom && !dropped;
                ram_waddr = cnt_mid[IW-1:0];
                ram_wdata = bottom_slot;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_page      <= PAGE_SIZE_RST;
            r_gutter    <= GUTTER_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PAGE_SIZE: r_page   <= i_cfg_data;
                    CFG_GUTTER:    r_gutter <= i_cfg_data[7:0];
                    default:       r_page   <= r_page;
                endcase
            end

            if (r_state == S_IDLE && in_acc && i_s_axis_tuser[0] == ACT_CLEAR) begin
                r_count <= CW'(1);
            end
            if (r_state == S_BOTTOM) begin
                r_count <= cnt_final;
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_need_w    <= need_w_in;
                r_need_h    <= need_h_in;
                r_rd_idx    <= '0;
                r_chk_valid <= 1'b0;
                r_status    <= ST_PLACED;
                r_pos_u     <= '0;
                r_pos_v     <= '0;
                r_full      <= 1'b0;
            end
            S_SEARCH: begin
                r_chk_valid <= issue;
                r_chk_idx   <= r_rd_idx[IW-1:0];
                if (issue) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
                if (hit) begin
                    r_used       <= rd_slot;
                    r_has_right  <= nb_right;
                    r_has_bottom <= nb_bottom;
                    r_pend       <= 1'b0;
                    if (nb_right) begin
                        r_src  <= r_chk_idx - IW'(1);
                        r_left <= CW'(r_chk_idx);
                    end else begin
                        r_src  <= r_chk_idx + IW'(1);
                        r_left <= r_count - CW'(1) - CW'(r_chk_idx);
                    end
                end else if (miss) begin
                    r_status <= ST_NO_FIT;
                    r_full   <= (r_count == '0);
                end
            end
            S_SHIFT: begin
                if (r_left != '0) begin
                    r_pend     <= 1'b1;
                    r_pend_dst <= r_has_right ? r_src + IW'(1) : r_src - IW'(1);
                    r_src      <= r_has_right ? r_src - IW'(1) : r_src + IW'(1);
                    r_left     <= r_left - CW'(1);
                end else begin
                    r_pend <= 1'b0;
                end
            end
            S_BOTTOM: begin
                r_status <= dropped ? ST_DROPPED : ST_PLACED;
                r_pos_u  <= r_used.u + {8'd0, r_gutter};
                r_pos_v  <= r_used.v + {8'd0, r_gutter};
                r_full   <= (cnt_final == '0);
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_data   <= {{(M_TDATA_W - 33){1'b0}}, r_full, r_pos_v, r_pos_u};
                end
            end
            default: begin
                r_pend <= r_pend;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
